/* hdl/assert_macros.svh */
// assertion macros for the checker file of the moving average unit
// each macro samples on i_clk; the first one is quiet while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define FCTMA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked at every edge, reset included
`define FCTMA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/fctma_pkg.sv */
// types, constants and helper functions for the four channel moving average unit
// no dependencies
package fctma_pkg;

    localparam int CHANNELS  = 4;
    localparam int SAMPLE_W  = 12;
    localparam int OFFSET_W  = 11;
    localparam int ENTRY_W   = 14;
    localparam int MEAN_W    = 14;
    localparam int CONV_W    = 14;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [OFFSET_W-1:0] t_offset;
    typedef logic signed [ENTRY_W-1:0]  t_entry;
    typedef logic signed [MEAN_W-1:0]   t_mean;
    typedef logic signed [CONV_W-1:0]   t_conv;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;

    // register indexes
    localparam t_cfg_idx REG_OFFSET_CH0 = 2'd0;
    localparam t_cfg_idx REG_OFFSET_CH1 = 2'd1;
    localparam t_cfg_idx REG_OFFSET_CH2 = 2'd2;
    localparam t_cfg_idx REG_OFFSET_CH3 = 2'd3;

    // -127 C in 1/16 C, sensor missing
    localparam t_sample DISCONNECTED = -12'sd2032;
    // 32 F in 1/16 F
    localparam t_conv   F_OFFSET     = 14'sd512;
    localparam t_entry  ENTRY_MAX    = 14'sd8191;
    localparam t_entry  ENTRY_MIN    = -14'sd8192;

    // exact divide by 5 for magnitudes below 2^15: ceil(2^18 / 5)
    localparam int          DIV5_S = 18;
    localparam logic [15:0] DIV5_M = 16'd52429;

    // clamp a 15 bit signed value to the 14 bit range
    function automatic t_entry sat14(input logic signed [ENTRY_W:0] v);
        t_entry res;
        if (v > (ENTRY_W+1)'(ENTRY_MAX)) begin
            res = ENTRY_MAX;
        end else if (v < (ENTRY_W+1)'(ENTRY_MIN)) begin
            res = ENTRY_MIN;
        end else begin
            res = ENTRY_W'(v);
        end
        return res;
    endfunction

    // celsius to fahrenheit, both in 1/16 degree, quotient truncated toward zero
    function automatic t_conv c_to_f(input t_sample raw);
        logic signed [15:0] x9;
        logic               neg;
        logic [14:0]        mag;
        logic [30:0]        prod;
        logic [11:0]        quo;
        t_conv              qs;
        x9   = (16'(raw) <<< 3) + 16'(raw);
        neg  = x9[15];
        mag  = neg ? 15'(-x9) : 15'(x9);
        prod = 31'(mag) * 31'(DIV5_M);
        quo  = prod[DIV5_S +: 12];
        qs   = neg ? -CONV_W'(quo) : CONV_W'(quo);
        return qs + F_OFFSET;
    endfunction

endpackage

/* hdl/fctma_ram.sv */
// generic single write port ram with one registered read port
// no dependencies
module fctma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/four_channel_temp_moving_average_unit.sv */
// four channel temperature boxcar averager, top level
// depends on fctma_pkg and fctma_ram
//
//  channel   direction   handshake                  payload
//  input     in          i_in_valid / o_in_stall    i_sample_ch0..i_sample_ch3
//  output    out         o_out_valid / i_out_stall  o_mean_ch0..o_mean_ch3
//  config    in          i_cfg_we                   i_cfg_idx, i_cfg_data
//
// one word in and one word out per clock when nothing stalls; an accepted word passes the input
// register, the sum stage and the output register before its result is valid
// the running sum loop sets the rate: divide by WINDOW, offset add and sum update in the same cycle
// reset is synchronous; a fill flag masks ring rows never written until the slot first wraps
// a held result word leaves room for two more words, in the sum stage and the input register
module four_channel_temp_moving_average_unit #(
    parameter int WINDOW = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input words
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fctma_pkg::t_sample  i_sample_ch0,
    input  fctma_pkg::t_sample  i_sample_ch1,
    input  fctma_pkg::t_sample  i_sample_ch2,
    input  fctma_pkg::t_sample  i_sample_ch3,
    // result words
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fctma_pkg::t_mean    o_mean_ch0,
    output fctma_pkg::t_mean    o_mean_ch1,
    output fctma_pkg::t_mean    o_mean_ch2,
    output fctma_pkg::t_mean    o_mean_ch3,
    // register writes
    input  logic                i_cfg_we,
    input  fctma_pkg::t_cfg_idx i_cfg_idx,
    input  fctma_pkg::t_offset  i_cfg_data
);

    localparam int CH      = fctma_pkg::CHANNELS;
    localparam int EW      = fctma_pkg::ENTRY_W;
    localparam int MW      = fctma_pkg::MEAN_W;
    localparam int SLOT_W  = $clog2(WINDOW);
    // window sum never exceeds WINDOW full scale entries
    localparam int SUM_W   = EW + SLOT_W;
    localparam int ROW_W   = CH * EW;
    // reciprocal of WINDOW, exact for every sum magnitude
    localparam int    DIV_S   = SUM_W + SLOT_W;
    localparam longint DIV_ML = ((longint'(1) << DIV_S) + WINDOW - 1) / WINDOW;
    localparam logic [SUM_W:0] DIV_M = (SUM_W+1)'(DIV_ML);
    localparam int PROD_W  = 2 * SUM_W + 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    // input stage
    logic                r_v1;
    fctma_pkg::t_conv    r_conv [CH];
    logic [CH-1:0]       r_disc;

    // window state
    logic signed [SUM_W-1:0] r_sum [CH];
    logic [SLOT_W-1:0]       r_slot;
    logic [SLOT_W-1:0]       n_slot;
    logic                    r_filled;
    logic                    r_v2;       // r_sum holds a mean not yet handed on

    // output register
    logic                r_ov;
    fctma_pkg::t_mean    r_mean [CH];

    fctma_pkg::t_offset  r_offset [CH];

    fctma_pkg::t_sample  w_sample [CH];
    fctma_pkg::t_mean    w_mean   [CH];
    logic signed [SUM_W-1:0] n_sum [CH];
    logic [ROW_W-1:0]    w_wrow;
    logic [ROW_W-1:0]    w_rrow;
    logic [SLOT_W-1:0]   w_raddr;

    logic w_in_accept;
    logic w_out_free;
    logic w_adv2;
    logic w_ready2;
    logic w_step;

    assign w_sample[0] = i_sample_ch0;
    assign w_sample[1] = i_sample_ch1;
    assign w_sample[2] = i_sample_ch2;
    assign w_sample[3] = i_sample_ch3;

    // pipeline flow
    assign w_out_free  = !r_ov || !i_out_stall;
    assign w_adv2      = r_v2 && w_out_free;
    assign w_ready2    = !r_v2 || w_adv2;
    assign w_step      = r_v1 && w_ready2;
    assign o_in_stall  = r_v1 && !w_ready2;
    assign w_in_accept = i_in_valid && !o_in_stall;

    // shared write slot, wraps at the end of the window
    assign n_slot  = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
    // read one slot ahead so the old entry is ready when the next word steps
    assign w_raddr = w_step ? n_slot : r_slot;

    fctma_ram #(
        .WIDTH (ROW_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_step),
        .i_waddr (r_slot),
        .i_wdata (w_wrow),
        .i_raddr (w_raddr),
        .o_rdata (w_rrow)
    );

    for (genvar c = 0; c < CH; c++) begin : g_ch
        logic                    w_neg;
        logic [SUM_W-1:0]        w_mag;
        logic [PROD_W-1:0]       w_prod;
        logic [MW-1:0]           w_quo;
        logic signed [MW:0]      w_qs;
        fctma_pkg::t_conv        w_val;
        fctma_pkg::t_entry       w_entry;
        fctma_pkg::t_entry       w_old;
        logic signed [SUM_W:0]   w_sum_ext;

        // mean of the current window, truncated toward zero
        // also the previous average a disconnected sensor falls back on
        assign w_neg  = r_sum[c][SUM_W-1];
        assign w_mag  = w_neg ? SUM_W'(-r_sum[c]) : SUM_W'(r_sum[c]);
        assign w_prod = PROD_W'(w_mag) * PROD_W'(DIV_M);
        assign w_quo  = w_prod[DIV_S +: MW];
        assign w_qs   = w_neg ? -(MW+1)'(w_quo) : (MW+1)'(w_quo);
        assign w_mean[c] = fctma_pkg::sat14(w_qs);

        assign w_val   = r_disc[c] ? w_mean[c] : r_conv[c];
        assign w_entry = fctma_pkg::sat14((EW+1)'(w_val) + (EW+1)'(r_offset[c]));
        // rows never written read as zero
        assign w_old   = r_filled ? fctma_pkg::t_entry'(w_rrow[c*EW +: EW]) : '0;

        assign w_sum_ext = (SUM_W+1)'(r_sum[c]) + (SUM_W+1)'(w_entry) - (SUM_W+1)'(w_old);
        assign n_sum[c]  = w_sum_ext[SUM_W-1:0];
        assign w_wrow[c*EW +: EW] = w_entry;
    end

    // input register: conversion done on the way in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_in_accept) begin
            r_v1 <= 1'b1;
        end else if (w_step) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            for (int c = 0; c < CH; c++) begin
                r_conv[c] <= fctma_pkg::c_to_f(w_sample[c]);
                r_disc[c] <= (w_sample[c] == fctma_pkg::DISCONNECTED);
            end
        end
    end

    // running sums and ring bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_filled <= 1'b0;
            r_v2     <= 1'b0;
            for (int c = 0; c < CH; c++) begin
                r_sum[c] <= '0;
            end
        end else begin
            if (w_step) begin
                r_slot <= n_slot;
                if (r_slot == LAST_SLOT) begin
                    r_filled <= 1'b1;
                end
                for (int c = 0; c < CH; c++) begin
                    r_sum[c] <= n_sum[c];
                end
            end
            if (w_step) begin
                r_v2 <= 1'b1;
            end else if (w_adv2) begin
                r_v2 <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv2) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            for (int c = 0; c < CH; c++) begin
                r_mean[c] <= w_mean[c];
            end
        end
    end

    // offset registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CH; c++) begin
                r_offset[c] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fctma_pkg::REG_OFFSET_CH0: begin
                    r_offset[0] <= i_cfg_data;
                end
                fctma_pkg::REG_OFFSET_CH1: begin
                    r_offset[1] <= i_cfg_data;
                end
                fctma_pkg::REG_OFFSET_CH2: begin
                    r_offset[2] <= i_cfg_data;
                end
                fctma_pkg::REG_OFFSET_CH3: begin
                    r_offset[3] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_mean_ch0  = r_mean[0];
    assign o_mean_ch1  = r_mean[1];
    assign o_mean_ch2  = r_mean[2];
    assign o_mean_ch3  = r_mean[3];

endmodule

/* hdl/fctma_checker.sv */
// port level checks for the moving average unit, bound to the top level
// depends on fctma_pkg and assert_macros.svh
`include "assert_macros.svh"

module fctma_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input fctma_pkg::t_mean    o_mean_ch0,
    input fctma_pkg::t_mean    o_mean_ch1,
    input fctma_pkg::t_mean    o_mean_ch2,
    input fctma_pkg::t_mean    o_mean_ch3
);

    // a held result word stays valid
    `FCTMA_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "result dropped")

    // a held result word keeps its means
    `FCTMA_ASSERT(a_out_stable, o_out_valid && i_out_stall |=> $stable(o_mean_ch0) && $stable(o_mean_ch1) && $stable(o_mean_ch2) && $stable(o_mean_ch3), "result changed while stalled")

    // the input only backs up when the output word is itself held
    `FCTMA_ASSERT(a_stall_cause, o_in_stall |-> o_out_valid && i_out_stall, "input stalled with room left")

    // reset empties the pipeline
    `FCTMA_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid && !o_in_stall, "pipeline not empty after reset")

endmodule

bind four_channel_temp_moving_average_unit fctma_checker u_fctma_checker (.*);
